### sv/pesid_pkg.sv
// Shared types and constants for the process entry sorter.
// Used by pesid_ctrl, pesid_chain and process_entry_sort_by_id_top.
// No dependencies.
package pesid_pkg;

    // Capacity of the sorting chain
    localparam int ENTRIES   = 64;
    localparam int ID_W      = 31;
    localparam int STATE_W   = 3;
    localparam int PAYLOAD_W = 2 * ID_W + STATE_W;
    localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;

    typedef struct packed {
        logic [STATE_W-1:0] run_state;
        logic [ID_W-1:0]    parent_id;
        logic [ID_W-1:0]    entry_id;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic insert;
        logic pop;
    } chain_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic head_is_final;
    } chain_status_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } ctrl_state_t;

endpackage

### sv/process_entry_sort_by_id_top.sv
// Top level of the process entry sorter: stream ports, controller and chain.
// Depends on pesid_pkg, pesid_ctrl, pesid_chain.
//
//  Channel | Dir | Beat contents                               | Marker
//  s_      | in  | tdata: entry_id, parent_id, run_state       | tlast: is_last
//  m_      | out | tdata: out_id, out_parent_id, out_state     | tlast: final_entry
//
// Load: one entry per cycle, set by the parallel compare-and-shift chain.
// After the last entry the batch drains one beat per cycle from the chain head
// while m_tready is high; no input is taken while draining.
// Reset empties the chain at once. A stall on m_tready holds the head beat.
module process_entry_sort_by_id_top
    import pesid_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    // [30:0] entry_id, [61:31] parent_id, [64:62] run_state, rest zero
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    // [30:0] out_id, [61:31] out_parent_id, [64:62] out_state, rest zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast
);

    chain_cmd_t    cmd;
    chain_status_t status;
    entry_t        in_entry;
    entry_t        head;

    assign in_entry = entry_t'(s_tdata[PAYLOAD_W-1:0]);

    pesid_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    pesid_chain u_chain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_entry (in_entry),
        .head     (head),
        .status   (status)
    );

    // Output beat straight from the chain head
    assign m_tdata = {{(TDATA_W - PAYLOAD_W){1'b0}}, head};
    assign m_tlast = status.head_is_final;

endmodule

### sv/pesid_ctrl.sv
// Controller for the process entry sorter: load phase, then drain phase.
// Depends on pesid_pkg.
module pesid_ctrl
    import pesid_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  logic          in_last,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  chain_status_t status,
    output chain_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_LOAD: begin
                in_ready   = 1'b1;
                cmd.insert = in_valid;
                if (in_valid && in_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                out_valid = 1'b1;
                cmd.pop   = out_ready;
                if (out_ready && status.head_is_final) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

### sv/pesid_chain.sv
// Systolic insertion chain: holds entries sorted by id, inserts one per cycle,
// drains from the head. Depends on pesid_pkg.
module pesid_chain
    import pesid_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  chain_cmd_t    cmd,
    input  entry_t        in_entry,
    output entry_t        head,
    output chain_status_t status
);

    entry_t             cell_reg  [ENTRIES];
    entry_t             cell_next [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] gt;

    // Each cell flags a stored id strictly above the new one (equal ids stay ahead)
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            gt[i] = valid_reg[i] && (cell_reg[i].entry_id > in_entry.entry_id);
        end
    end

    // Per-cell next value: hold, take new entry, shift up on insert, shift down on pop
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            cell_next[i]  = cell_reg[i];
            valid_next[i] = valid_reg[i];
            if (cmd.pop) begin
                if (i == ENTRIES - 1) begin
                    valid_next[i] = 1'b0;
                end else begin
                    cell_next[i]  = cell_reg[i+1];
                    valid_next[i] = valid_reg[i+1];
                end
            end else if (cmd.insert && !valid_reg[ENTRIES-1]) begin
                if (i > 0 && gt[i-1]) begin
                    cell_next[i]  = cell_reg[i-1];
                    valid_next[i] = 1'b1;
                end else if (gt[i] || (!valid_reg[i] && (i == 0 || valid_reg[i-1]))) begin
                    cell_next[i]  = in_entry;
                    valid_next[i] = 1'b1;
                end
            end
        end
    end

    // Payload cells, no reset
    always_ff @(posedge aclk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            cell_reg[i] <= cell_next[i];
        end
    end

    // Occupancy flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign head                 = cell_reg[0];
    assign status.head_is_final = !valid_reg[1];

endmodule

### tb/testbench.sv
// Self-checking testbench for process_entry_sort_by_id_top: stream stimulus,
// a stable insertion-sort predictor, and a beat-by-beat check of the output.
// Depends on pesid_pkg and the RTL of the sorter.
module testbench;
    import pesid_pkg::*;

    localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

    // One expected output beat
    typedef struct packed {
        entry_t e;
        logic   fin;
    } sorted_beat_t;

    // One row of the directed table
    typedef struct packed {
        entry_t e;
        logic   last;
        logic   typed;
        entry_t want;
    } dir_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    // [30:0] entry_id, [61:31] parent_id, [64:62] run_state, rest zero
    logic [TDATA_W-1:0] s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    // [30:0] out_id, [61:31] out_parent_id, [64:62] out_state, rest zero
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;

    // Predictor state: the batch held in ascending id order
    entry_t       sorted_store [ENTRIES];
    int           sorted_count;
    sorted_beat_t sorted_out_due [$];
    dir_row_t     dir_rows [$];

    int mismatch_count;
    int sent_count;
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_req;
    bit hold_done;
    int hold_left;

    process_entry_sort_by_id_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Stable insert; a full store drops the entry but still honors the last flag
    task automatic sort_take_entry(input entry_t e, input logic last);
        int pos;
        if (sorted_count < ENTRIES) begin
            pos = sorted_count;
            while (pos > 0 && sorted_store[pos-1].entry_id > e.entry_id) begin
                sorted_store[pos] = sorted_store[pos-1];
                pos--;
            end
            sorted_store[pos] = e;
            sorted_count++;
        end
        if (last) begin
            for (int k = 0; k < sorted_count; k++)
                sorted_out_due.push_back('{e: sorted_store[k], fin: (k == sorted_count - 1)});
            sorted_count = 0;
        end
    endtask

    // Drive one beat, wait for the handshake; idle percentages follow the beat count
    task automatic send_entry(input entry_t e, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(e);
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sent_count++;
        if (sent_count < 120) begin
            tx_idle_pct = 8;
            rx_idle_pct = 65;
        end else if (sent_count < 230) begin
            tx_idle_pct = 65;
            rx_idle_pct = 8;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    // Small id range in four draws of ten so equal ids come up often
    function automatic entry_t rand_entry();
        entry_t e;
        case ($urandom_range(0, 9))
            0: e.entry_id = '0;
            1: e.entry_id = ID_MAX;
            2, 3, 4, 5: e.entry_id = ID_W'($urandom_range(0, 15));
            default: e.entry_id = ID_W'($urandom);
        endcase
        e.parent_id = ID_W'($urandom);
        e.run_state = STATE_W'($urandom_range(0, 7));
        return e;
    endfunction

    task automatic add_row(input logic [ID_W-1:0] id, input logic [ID_W-1:0] par,
                           input logic [STATE_W-1:0] st, input logic last,
                           input logic typed, input logic [ID_W-1:0] w_id,
                           input logic [ID_W-1:0] w_par, input logic [STATE_W-1:0] w_st);
        dir_row_t r;
        r.e     = '{run_state: st, parent_id: par, entry_id: id};
        r.last  = last;
        r.typed = typed;
        r.want  = '{run_state: w_st, parent_id: w_par, entry_id: w_id};
        dir_rows.push_back(r);
    endtask

    // Output monitor and receiver backpressure
    always @(posedge aclk) begin
        sorted_beat_t exp_b;
        entry_t       got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[PAYLOAD_W-1:0];
            if (sorted_out_due.size() == 0) begin
                $display("%0t: unexpected beat id=%h parent=%h state=%0d last=%b",
                         $time, got.entry_id, got.parent_id, got.run_state, m_tlast);
                mismatch_count++;
            end else begin
                exp_b = sorted_out_due.pop_front();
                if (got.entry_id !== exp_b.e.entry_id) begin
                    $display("%0t: out_id expected %h got %h",
                             $time, exp_b.e.entry_id, got.entry_id);
                    mismatch_count++;
                end
                if (got.parent_id !== exp_b.e.parent_id) begin
                    $display("%0t: out_parent_id expected %h got %h",
                             $time, exp_b.e.parent_id, got.parent_id);
                    mismatch_count++;
                end
                if (got.run_state !== exp_b.e.run_state) begin
                    $display("%0t: out_state expected %0d got %0d",
                             $time, exp_b.e.run_state, got.run_state);
                    mismatch_count++;
                end
                if (m_tlast !== exp_b.fin) begin
                    $display("%0t: final_entry expected %b got %b",
                             $time, exp_b.fin, m_tlast);
                    mismatch_count++;
                end
            end
        end
        // Long hold-off, counted here, while the chain fills; a full chain drops entries, it does not stall its input
        if (hold_req && !hold_done) begin
            hold_left = 400;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Run limit
    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Stimulus
    initial begin
        int     batch_len;
        entry_t e;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        aresetn        = 1'b0;
        sorted_count   = 0;
        mismatch_count = 0;
        sent_count     = 0;
        tx_idle_pct    = 8;
        rx_idle_pct    = 65;
        hold_req       = 1'b0;
        hold_done      = 1'b0;
        hold_left      = 0;

        // Single-entry batches from an empty store come back unchanged
        add_row(ID_MAX, '0, 3'd7, 1'b1, 1'b1, ID_MAX, '0, 3'd7);
        add_row('0, ID_MAX, 3'd0, 1'b1, 1'b1, '0, ID_MAX, 3'd0);
        add_row(31'h5555_5555, 31'h2AAA_AAAA, 3'd5, 1'b1, 1'b1,
                31'h5555_5555, 31'h2AAA_AAAA, 3'd5);
        add_row(31'h2AAA_AAAA, 31'h5555_5555, 3'd2, 1'b1, 1'b1,
                31'h2AAA_AAAA, 31'h5555_5555, 3'd2);
        // Out of order with equal ids: arrival order kept among equals
        add_row(31'd30, 31'd1, 3'd1, 1'b0, 1'b0, '0, '0, '0);
        add_row(31'd10, 31'd2, 3'd2, 1'b0, 1'b0, '0, '0, '0);
        add_row(31'd30, 31'd3, 3'd3, 1'b0, 1'b0, '0, '0, '0);
        add_row(31'd10, 31'd4, 3'd4, 1'b0, 1'b0, '0, '0, '0);
        add_row(ID_MAX, 31'd5, 3'd6, 1'b0, 1'b0, '0, '0, '0);
        add_row('0, 31'd6, 3'd7, 1'b1, 1'b0, '0, '0, '0);
        // Already ascending
        add_row(31'd1, '0, 3'd0, 1'b0, 1'b0, '0, '0, '0);
        add_row(31'd2, '0, 3'd1, 1'b0, 1'b0, '0, '0, '0);
        add_row(31'd3, ID_MAX, 3'd3, 1'b1, 1'b0, '0, '0, '0);
        // All ids equal
        add_row(31'd5, 31'd11, 3'd0, 1'b0, 1'b0, '0, '0, '0);
        add_row(31'd5, 31'd12, 3'd1, 1'b0, 1'b0, '0, '0, '0);
        add_row(31'd5, 31'd13, 3'd2, 1'b1, 1'b0, '0, '0, '0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table; typed rows leave the predictor's store empty
        foreach (dir_rows[i]) begin
            send_entry(dir_rows[i].e, dir_rows[i].last);
            if (dir_rows[i].typed)
                sorted_out_due.push_back('{e: dir_rows[i].want, fin: 1'b1});
            else
                sort_take_entry(dir_rows[i].e, dir_rows[i].last);
        end

        // Overfull batch under a long receiver hold-off; the last six entries are dropped
        for (int i = 0; i < ENTRIES + 6; i++) begin
            e = rand_entry();
            send_entry(e, i == ENTRIES + 5);
            sort_take_entry(e, i == ENTRIES + 5);
            // Hold-off starts once this batch is loading, so it covers the full chain
            if (i == 0)
                hold_req = 1'b1;
        end

        // Random batches, mostly short, now and then up to past capacity
        while (sent_count < 320) begin
            if ($urandom_range(0, 9) == 0)
                batch_len = $urandom_range(9, ENTRIES + 6);
            else
                batch_len = $urandom_range(1, 8);
            for (int i = 0; i < batch_len; i++) begin
                e = rand_entry();
                send_entry(e, i == batch_len - 1);
                sort_take_entry(e, i == batch_len - 1);
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (sorted_out_due.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
